// ===== src/packed_grid_value_decoder_defines.svh =====
// Assertion macros for the packed grid value decoder checker.
// Used by src/pgvd_checker.sv; the clock and reset are taken as clk and rst.
`ifndef PACKED_GRID_VALUE_DECODER_DEFINES_SVH
`define PACKED_GRID_VALUE_DECODER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PGVD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PGVD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PGVD_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pgvd_pkg.sv =====
// Shared types and constants of the packed grid value decoder.
// Used by every module of the block; depends on nothing else.
package pgvd_pkg;

  // Fixed field widths.
  localparam int BYTE_BITS   = 8;
  localparam int COUNT_W     = 32;
  localparam int VALUE_W     = 64;
  localparam int GAIN_W      = 40;
  localparam int GAIN_SPLIT  = 20;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int WIDTH_IN_W  = 5;

  // Reset values of the configuration registers.
  localparam int                 WIDTH_RESET = 8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 40'h01_0000_0000;

  // Flipping the sign bit maps signed order onto unsigned order.
  localparam logic [VALUE_W-1:0] SIGN_BIAS = 64'h8000_0000_0000_0000;

  // Code queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BITS_PER_VALUE = 2'd0,
    REG_PIXEL_COUNT    = 2'd1,
    REG_VALUE_OFFSET   = 2'd2,
    REG_VALUE_GAIN     = 2'd3
  } cfg_reg_t;

  // Markers that travel with each code.
  typedef struct packed {
    logic last_of_byte;
    logic last_pixel;
  } code_flags_t;

endpackage

// ===== src/pgvd_queue.sv =====
// Short code queue that decouples the bit unpacker from the scaling pipeline.
// Depends on pgvd_pkg for the depth and the flag type.
module pgvd_queue
  import pgvd_pkg::*;
#(
  parameter int CODE_W = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [CODE_W-1:0] push_code,
  input  code_flags_t       push_flags,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [CODE_W-1:0] head_code,
  output code_flags_t       head_flags
);

  logic [CODE_W-1:0] code_mem [QUEUE_DEPTH];
  code_flags_t       flag_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_code  = code_mem[rd_ptr];
  assign head_flags = flag_mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      code_mem[wr_ptr] <= push_code;
      flag_mem[wr_ptr] <= push_flags;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== src/pgvd_front.sv =====
// Decoder front: cuts packed bytes to codes, one per cycle while the queue has room.
// Holds the code width and pixel count registers; depends on pgvd_pkg.
module pgvd_front
  import pgvd_pkg::*;
#(
  parameter int MAX_CODE_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [BYTE_BITS-1:0]      data_byte,
  input  logic                      first_byte,
  input  logic                      q_full,
  output logic                      push,
  output logic [MAX_CODE_WIDTH-1:0] push_code,
  output code_flags_t               push_flags
);

  localparam int BUF_W  = MAX_CODE_WIDTH + BYTE_BITS - 1;
  localparam int HELD_W = $clog2(MAX_CODE_WIDTH + BYTE_BITS);

  logic [HELD_W-1:0]  code_width;
  logic [COUNT_W-1:0] pixel_count;
  logic [BUF_W-1:0]   bit_buffer;
  logic [BUF_W-1:0]   bit_buffer_next;
  logic [HELD_W-1:0]  bits_held;
  logic [HELD_W-1:0]  bits_held_next;
  logic [COUNT_W-1:0] pixels_done;
  logic [COUNT_W-1:0] pixels_done_next;

  logic               busy;
  logic [HELD_W-1:0]  shift_amt;
  logic [COUNT_W-1:0] done_inc;
  logic               ends_section;
  logic               ends_byte;
  logic [BUF_W-1:0]   code_mask;
  logic [BUF_W-1:0]   keep_mask;
  logic [BUF_W-1:0]   shifted;
  logic               accept;
  logic [5:0]         width_clamped;
  logic               width_write;

  assign width_write = cfg_wen && (cfg_index == REG_BITS_PER_VALUE);

  // Width written as zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    width_clamped = {1'b0, cfg_wdata[WIDTH_IN_W-1:0]};
    if (width_clamped == 6'd0) begin
      width_clamped = 6'd1;
    end else if (width_clamped > 6'(MAX_CODE_WIDTH)) begin
      width_clamped = 6'(MAX_CODE_WIDTH);
    end
  end

  // Code extraction from the top of the held bits.
  always_comb begin
    busy         = (bits_held >= code_width) && (pixels_done < pixel_count);
    shift_amt    = bits_held - code_width;
    done_inc     = pixels_done + 1'b1;
    ends_section = (done_inc == pixel_count);
    ends_byte    = ends_section || (shift_amt < code_width);
    code_mask    = (BUF_W'(1) << code_width) - BUF_W'(1);
    keep_mask    = (BUF_W'(1) << shift_amt) - BUF_W'(1);
    shifted      = bit_buffer >> shift_amt;
    push_code    = MAX_CODE_WIDTH'(shifted & code_mask);
    push_flags   = '{last_of_byte: ends_byte, last_pixel: ends_section};
    push         = busy && !q_full;
    // A new byte may enter in the cycle that takes the last code of the current one.
    s_tready     = !busy || (!q_full && ends_byte);
    accept       = s_tvalid && s_tready;
  end

  // Next bit buffer state: extraction, then the incoming byte, then a width write.
  always_comb begin
    bit_buffer_next  = bit_buffer;
    bits_held_next   = bits_held;
    pixels_done_next = pixels_done;
    if (push) begin
      pixels_done_next = done_inc;
      if (ends_section) begin
        bit_buffer_next = '0;
        bits_held_next  = '0;
      end else begin
        bit_buffer_next = bit_buffer & keep_mask;
        bits_held_next  = shift_amt;
      end
    end
    if (accept) begin
      if (first_byte) begin
        bit_buffer_next  = '0;
        bits_held_next   = '0;
        pixels_done_next = '0;
      end
      // Bytes after a completed section are dropped.
      if (pixels_done_next < pixel_count) begin
        bit_buffer_next = {bit_buffer_next[BUF_W-BYTE_BITS-1:0], data_byte};
        bits_held_next  = bits_held_next + HELD_W'(BYTE_BITS);
      end
    end
    if (width_write) begin
      bit_buffer_next = '0;
      bits_held_next  = '0;
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_width  <= HELD_W'(WIDTH_RESET);
      pixel_count <= COUNT_RESET;
      bit_buffer  <= '0;
      bits_held   <= '0;
      pixels_done <= '0;
    end else begin
      bit_buffer  <= bit_buffer_next;
      bits_held   <= bits_held_next;
      pixels_done <= pixels_done_next;
      if (width_write) begin
        code_width <= HELD_W'(width_clamped);
      end
      if (cfg_wen && (cfg_index == REG_PIXEL_COUNT)) begin
        pixel_count <= cfg_wdata[COUNT_W-1:0];
      end
    end
  end

endmodule

// ===== src/pgvd_scale.sv =====
// Back of the decoder: offset + code * gain in Q32.32 with saturation.
// Holds the offset and gain registers; depends on pgvd_pkg.
module pgvd_scale
  import pgvd_pkg::*;
#(
  parameter int CODE_W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   head_valid,
  input  logic [CODE_W-1:0]      head_code,
  input  code_flags_t            head_flags,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [VALUE_W-1:0]     grid_value,
  output code_flags_t            out_flags
);

  localparam int PROD_W = CODE_W + GAIN_SPLIT;

  logic [VALUE_W-1:0] offset_biased;
  logic               gain_neg;
  logic [GAIN_W-1:0]  gain_mag;
  logic [GAIN_W-1:0]  gain_in;

  logic               advance;
  logic               s1_valid;
  code_flags_t        s1_flags;
  logic [PROD_W-1:0]  p_lo;
  logic [PROD_W-1:0]  p_hi;
  logic               s2_valid;
  code_flags_t        s2_flags;
  logic [VALUE_W-1:0] product;
  logic [VALUE_W:0]   sum_pos;
  logic [VALUE_W-1:0] biased_result;

  assign gain_in = cfg_wdata[GAIN_W-1:0];
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && head_valid;

  // Offset kept biased, gain kept as sign and magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_biased <= SIGN_BIAS;
      gain_neg      <= 1'b0;
      gain_mag      <= GAIN_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == REG_VALUE_OFFSET) begin
        offset_biased <= cfg_wdata[VALUE_W-1:0] ^ SIGN_BIAS;
      end
      if (cfg_index == REG_VALUE_GAIN) begin
        gain_neg <= gain_in[GAIN_W-1];
        gain_mag <= gain_in[GAIN_W-1] ? (~gain_in + 1'b1) : gain_in;
      end
    end
  end

  // Saturating add or subtract in biased form.
  always_comb begin
    sum_pos = {1'b0, offset_biased} + {1'b0, product};
    if (!gain_neg) begin
      biased_result = sum_pos[VALUE_W] ? '1 : sum_pos[VALUE_W-1:0];
    end else begin
      biased_result = (product > offset_biased) ? '0 : (offset_biased - product);
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

  // Partial products, their sum, then the saturated result.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_flags   <= head_flags;
      p_lo       <= PROD_W'(head_code) * PROD_W'(gain_mag[GAIN_SPLIT-1:0]);
      p_hi       <= PROD_W'(head_code) * PROD_W'(gain_mag[GAIN_W-1:GAIN_SPLIT]);
      s2_flags   <= s1_flags;
      product    <= VALUE_W'(p_lo) + (VALUE_W'(p_hi) << GAIN_SPLIT);
      out_flags  <= s2_flags;
      grid_value <= biased_result ^ SIGN_BIAS;
    end
  end

endmodule

// ===== src/packed_grid_value_decoder.sv =====
// Top level of the packed grid value decoder.
// Instantiates pgvd_front, pgvd_queue and pgvd_scale; depends on pgvd_pkg.
//
// Use: packed data-section bytes enter on the s_ channel, most significant bit
// first, with s_tuser marking the first byte of a section. Each code of the
// configured width comes out on the m_ channel as a signed Q32.32 value.
// m_tlast marks the value that completes the pixel count, m_tuser the last
// value caused by its byte. Registers are written through cfg_wen, cfg_index
// and cfg_wdata while no transaction is in flight.
// The first value of a byte passes the bit buffer, the queue, stages s1 and s2
// and the output register before it leaves. Throughput: one value per cycle
// while the receiver does not stall, set by the front unpacker taking one code
// per cycle; a byte that yields several values occupies it until its last code
// is taken, so a byte per cycle is taken for widths of eight bits or more.
// Reset empties the bit buffer, the queue and the pipeline and restores the
// register defaults (width 8, one pixel, offset 0, gain 1.0).
// When the receiver stalls the pipeline holds, the four-entry queue fills
// and then s_tready drops.
module packed_grid_value_decoder
  import pgvd_pkg::*;
#(
  parameter int MAX_CODE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,  // [7:0] data_byte
  input  logic [0:0]             s_tuser,  // [0] first_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [63:0]            m_tdata,  // [63:0] grid_value
  output logic [0:0]             m_tuser,  // [0] last_of_byte
  output logic                   m_tlast   // last_pixel
);

  logic                      q_push;
  logic [MAX_CODE_WIDTH-1:0] q_push_code;
  code_flags_t               q_push_flags;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_head_valid;
  logic [MAX_CODE_WIDTH-1:0] q_head_code;
  code_flags_t               q_head_flags;
  code_flags_t               out_flags;

  // Byte unpacker.
  pgvd_front #(
    .MAX_CODE_WIDTH(MAX_CODE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .data_byte  (s_tdata),
    .first_byte (s_tuser[0]),
    .q_full     (q_full),
    .push       (q_push),
    .push_code  (q_push_code),
    .push_flags (q_push_flags)
  );

  // Code queue.
  pgvd_queue #(
    .CODE_W(MAX_CODE_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_code  (q_push_code),
    .push_flags (q_push_flags),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_code  (q_head_code),
    .head_flags (q_head_flags)
  );

  // Scaling pipeline.
  pgvd_scale #(
    .CODE_W(MAX_CODE_WIDTH)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head_code  (q_head_code),
    .head_flags (q_head_flags),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .grid_value (m_tdata),
    .out_flags  (out_flags)
  );

  assign m_tuser[0] = out_flags.last_of_byte;
  assign m_tlast    = out_flags.last_pixel;

endmodule

// ===== src/pgvd_checker.sv =====
// Port-level checker for the packed grid value decoder, bound to the top level.
// Depends on packed_grid_value_decoder_defines.svh for the assertion macros.
`include "packed_grid_value_decoder_defines.svh"

module pgvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result holds its value.
  `PGVD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // The value that completes a section is also the last one of its byte.
  `PGVD_ASSERT_IMP(a_last_pixel_ends_byte, m_tvalid && m_tlast, m_tuser[0], "last pixel without last of byte")

  // Reset leaves no result pending and the input open.
  `PGVD_ASSERT_RST(a_reset_empty, rst, !m_tvalid && s_tready, "block not empty after reset")

endmodule

bind packed_grid_value_decoder pgvd_checker u_checker (.*);

// ===== bench/packed_grid_value_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for packed_grid_value_decoder: bytes in, Q32.32 values out.
// Depends on pgvd_pkg for the register indexes and on the block's RTL only.
module packed_grid_value_decoder_test;
  import pgvd_pkg::*;

  // One packed byte waiting to be offered, with its section-start flag.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } section_byte_t;

  // One decoded value as the block should deliver it.
  typedef struct packed {
    logic [63:0] value;
    logic        last_of_byte;
    logic        last_pixel;
  } grid_result_t;

  localparam int                 WIDEST_CODE = 24;
  localparam logic signed [71:0] VALUE_MAX   = 72'sh00_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [71:0] VALUE_MIN   = -72'sh00_8000_0000_0000_0000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_BITS_PER_VALUE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'd0;   // [7:0] data_byte
  logic [0:0]             s_tuser = 1'b0;   // [0] first_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [63:0]            m_tdata;          // [63:0] grid_value
  logic [0:0]             m_tuser;          // [0] last_of_byte
  logic                   m_tlast;          // last_pixel

  packed_grid_value_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bench copy of the registers and the unpacking state.
  logic [4:0]         width_reg  = 5'd8;
  logic [31:0]        count_reg  = 32'd1;
  logic signed [63:0] offset_reg = 64'sd0;
  logic signed [39:0] gain_reg   = 40'sh01_0000_0000;
  logic [63:0]        held_bits  = 64'd0;
  int unsigned        held_count = 0;
  logic [31:0]        pixels_done = 32'd0;

  section_byte_t pending_bytes[$];
  grid_result_t  expected_values[$];
  int            mismatches = 0;
  int            send_gap_max = 4;
  int            rx_stall_max = 4;
  logic          rx_hold = 1'b0;

  // Effective code width: zero acts as one, anything wide is clamped.
  function automatic int unsigned code_width();
    if (width_reg == 5'd0) return 1;
    if (width_reg > WIDEST_CODE) return WIDEST_CODE;
    return width_reg;
  endfunction

  // offset + code * gain, saturated to the signed 64-bit range.
  function automatic logic [63:0] scaled_value(logic [23:0] code);
    logic signed [71:0] off_x;
    logic signed [71:0] gain_x;
    logic signed [71:0] code_x;
    logic signed [71:0] total;
    off_x  = offset_reg;
    gain_x = gain_reg;
    code_x = {48'd0, code};
    total  = off_x + code_x * gain_x;
    if (total > VALUE_MAX) return VALUE_MAX[63:0];
    if (total < VALUE_MIN) return VALUE_MIN[63:0];
    return total[63:0];
  endfunction

  // Takes one accepted byte and queues every value it should produce.
  function automatic void decode_byte(logic [7:0] data, logic first);
    int unsigned  w;
    int unsigned  shift;
    int           produced;
    logic         more;
    grid_result_t r;
    w = code_width();
    produced = 0;
    if (first) begin
      held_bits = 64'd0;
      held_count = 0;
      pixels_done = 32'd0;
    end
    if (pixels_done >= count_reg) return;
    held_bits = (held_bits << 8) | {56'd0, data};
    held_count += 8;
    while (held_count >= w && pixels_done < count_reg && produced < 8) begin
      shift = held_count - w;
      r.value = scaled_value(24'((held_bits >> shift) & ((64'd1 << w) - 64'd1)));
      held_count = shift;
      held_bits &= (64'd1 << shift) - 64'd1;
      pixels_done++;
      produced++;
      more = held_count >= w && pixels_done < count_reg && produced < 8;
      r.last_of_byte = !more;
      r.last_pixel = (pixels_done == count_reg);
      expected_values.push_back(r);
    end
    // A finished section throws away its padding bits.
    if (pixels_done >= count_reg) begin
      held_bits = 64'd0;
      held_count = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  // Driver: offers queued bytes, with a random gap before each one.
  int send_gap = 0;
  always @(posedge clk) begin
    logic          offering;
    section_byte_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser[0]);
        offering = 1'b0;
        send_gap = $urandom_range(0, send_gap_max);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          item = pending_bytes.pop_front();
          s_tdata <= item.data;
          s_tuser <= item.first;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every value transaction and stalls at random.
  int rx_stall = 0;
  always @(posedge clk) begin
    grid_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected value", m_tdata, 64'd0);
        end else begin
          want = expected_values.pop_front();
          if (m_tdata !== want.value) report_mismatch("grid_value", m_tdata, want.value);
          if (m_tuser[0] !== want.last_of_byte)
            report_mismatch("last_of_byte", 64'(m_tuser[0]), 64'(want.last_of_byte));
          if (m_tlast !== want.last_pixel)
            report_mismatch("last_pixel", 64'(m_tlast), 64'(want.last_pixel));
        end
        rx_stall = $urandom_range(0, rx_stall_max);
      end
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(logic [7:0] data, logic first);
    section_byte_t item;
    item.data = data;
    item.first = first;
    pending_bytes.push_back(item);
  endtask

  // Writes one register and mirrors it in the bench copy.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_BITS_PER_VALUE: begin
        width_reg = value[4:0];
        held_bits = 64'd0;
        held_count = 0;
      end
      REG_PIXEL_COUNT: count_reg = value[31:0];
      REG_VALUE_OFFSET: offset_reg = value;
      REG_VALUE_GAIN: gain_reg = value[39:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the sender until every byte is taken and every value has arrived.
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_values.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  // One random register setting followed by sections of random content.
  task automatic random_phase(int target, int forced_width, bit hold_output,
                              int gap_limit, int stall_limit);
    logic [4:0]  width_val;
    logic [31:0] count_val;
    logic [63:0] offset_val;
    logic [39:0] gain_val;
    int          w;
    int          sent;
    int          section_len;
    int          k;
    case ($urandom_range(0, 9))
      0: width_val = 5'd0;
      1: width_val = 5'($urandom_range(25, 31));
      default: width_val = 5'($urandom_range(1, 24));
    endcase
    if (forced_width >= 0) width_val = 5'(forced_width);
    if ($urandom_range(0, 7) == 0 || hold_output)
      count_val = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    else
      count_val = 32'($urandom_range(1, 12));
    case ($urandom_range(0, 5))
      0: offset_val = 64'h7FFF_FFFF_FFFF_FFFF;
      1: offset_val = 64'h8000_0000_0000_0000;
      2: offset_val = {$urandom, $urandom};
      default: offset_val = {{24{$urandom_range(0, 1) == 1}}, 40'({$urandom, $urandom})};
    endcase
    case ($urandom_range(0, 5))
      0: gain_val = 40'h7F_FFFF_FFFF;
      1: gain_val = 40'h80_0000_0000;
      2: gain_val = 40'({$urandom, $urandom});
      default: gain_val = {{6{$urandom_range(0, 1) == 1}}, 34'({$urandom, $urandom})};
    endcase
    write_reg(REG_VALUE_GAIN, {24'd0, gain_val});
    write_reg(REG_VALUE_OFFSET, offset_val);
    write_reg(REG_PIXEL_COUNT, {32'd0, count_val});
    write_reg(REG_BITS_PER_VALUE, {59'd0, width_val});
    send_gap_max <= gap_limit;
    rx_stall_max <= stall_limit;
    @(negedge clk);
    w = code_width();

    // Mostly whole sections; some are cut short or restarted mid-way.
    sent = 0;
    while (sent < target) begin
      if (count_val > 32'd64) section_len = $urandom_range(4, 16);
      else section_len = (int'(count_val) * w + 7) / 8;
      if ($urandom_range(0, 7) == 0) section_len = $urandom_range(1, section_len);
      for (k = 0; k < section_len; k++)
        push_byte(8'($urandom), k == 0 || $urandom_range(0, 19) == 0);
      sent += section_len;
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
    end

    // Long receiver stall so that the block backs up onto its input.
    if (hold_output) begin
      rx_hold <= 1'b1;
      repeat (150) @(posedge clk);
      rx_hold <= 1'b0;
    end
    drain();
  endtask

  // Stimulus: directed cases first, then random phases.
  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: one 8-bit pixel, then the section is complete.
    push_byte(8'hA5, 1'b1);
    push_byte(8'h3C, 1'b0);
    drain();

    // Width zero acts as one bit: eight values from one byte.
    write_reg(REG_BITS_PER_VALUE, 64'd0);
    write_reg(REG_PIXEL_COUNT, 64'd8);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b1);
    drain();

    // Oversized width clamps to 24 bits; largest offset and gain saturate high.
    write_reg(REG_BITS_PER_VALUE, 64'd31);
    write_reg(REG_PIXEL_COUNT, 64'd2);
    write_reg(REG_VALUE_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_VALUE_GAIN, 64'h7F_FFFF_FFFF);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    drain();

    // Most negative offset and gain saturate low.
    write_reg(REG_VALUE_OFFSET, 64'h8000_0000_0000_0000);
    write_reg(REG_VALUE_GAIN, 64'h80_0000_0000);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    drain();

    // A pixel count of zero drops every byte.
    write_reg(REG_PIXEL_COUNT, 64'd0);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    drain();

    // A width write empties the bit buffer but keeps the pixel count.
    write_reg(REG_VALUE_OFFSET, 64'd0);
    write_reg(REG_VALUE_GAIN, 64'hFF_0000_0000);
    write_reg(REG_PIXEL_COUNT, 64'd3);
    write_reg(REG_BITS_PER_VALUE, 64'd12);
    push_byte(8'hAB, 1'b1);
    drain();
    write_reg(REG_BITS_PER_VALUE, 64'd4);
    push_byte(8'hCD, 1'b0);
    push_byte(8'hEF, 1'b0);
    drain();

    for (phase = 0; phase < 8; phase++)
      random_phase(20, (phase == 2) ? 1 : -1, phase == 2,
                   (phase % 3 == 1) ? 0 : 4, (phase % 4 == 3) ? 0 : 4);

    if (mismatches == 0) begin
      $display("[packed_grid_value_decoder] OK");
    end else begin
      $display("[packed_grid_value_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[packed_grid_value_decoder] ERROR");
    $finish;
  end

endmodule

// ===== packed_grid_value_decoder.f =====
+incdir+src
src/pgvd_pkg.sv
src/pgvd_queue.sv
src/pgvd_front.sv
src/pgvd_scale.sv
src/packed_grid_value_decoder.sv
src/pgvd_checker.sv
bench/packed_grid_value_decoder_test.sv
